// ===== hw/rtl/first_fit_heap_allocator_core_defines.svh =====
// Assertion macros used by the allocator datapath RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// ===== hw/rtl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 17;
	localparam int GRAIN            = 8;
	localparam int DATA_W           = 32;
	localparam int STATUS_W         = 3;
	localparam int LIVE_W           = 13;
	localparam int REG_ADDR_W       = 3;

	// highest top offset that stays aligned below 2^32
	localparam logic [DATA_W-1:0] TOP_LIMIT      = 32'hFFFF_FFF8;
	localparam logic [DATA_W-1:0] REGION_LEN_RST = 32'd65536;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_OOM     = 3'd2,
		ST_BADADDR = 3'd3,
		ST_DOUBLE  = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		REG_HEAP_BASE  = 1'b0,
		REG_REGION_LEN = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic early;
		logic found;
		logic exhausted;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/ffha_if.sv =====
// Request and response channel interfaces of the allocator.
interface ffha_req_if import ffha_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [DATA_W-1:0] req_size;
	logic [DATA_W-1:0] user_addr;

	modport source (output valid, output op, output req_size, output user_addr, input ready);
	modport sink   (input valid, input op, input req_size, input user_addr, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   result_addr;
	logic [DATA_W-1:0]   bytes_in_use;
	logic [LIVE_W-1:0]   live_blocks;

	modport source (output valid, output status, output result_addr, output bytes_in_use,
		output live_blocks, input ready);
	modport sink   (input valid, input status, input result_addr, input bytes_in_use,
		input live_blocks, output ready);
endinterface

// ===== hw/rtl/ffha_ctrl.sv =====
// Sequencing state machine of the allocator: accept, scan, commit.
module ffha_ctrl import ffha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				// zero size / null free need no table walk
				if (sts.early) begin
					state_d = S_COMMIT;
				end else begin
					cmd.step = 1'b1;
					if (sts.found || sts.exhausted) begin
						state_d = S_COMMIT;
					end
				end
			end
			S_COMMIT: begin
				// wait for the response register to drain
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ffha_dp.sv =====
// Allocator datapath: block table memory, scan compare, totals, response register.
`include "first_fit_heap_allocator_core_defines.svh"
module ffha_dp import ffha_pkg::*; #(
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                op,
	input  logic [DATA_W-1:0]   req_size,
	input  logic [DATA_W-1:0]   user_addr,
	input  logic [DATA_W-1:0]   heap_base,
	input  logic [DATA_W-1:0]   region_len,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output logic [STATUS_W-1:0] status,
	output logic [DATA_W-1:0]   result_addr,
	output logic [DATA_W-1:0]   bytes_in_use,
	output logic [LIVE_W-1:0]   live_blocks
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [DATA_W-1:0] HDR  = DATA_W'(HEADER_BYTES);
	localparam logic [CW-1:0]     MAXB = CW'(MAX_BLOCKS);
	localparam logic [DATA_W:0]   RND  = (DATA_W+1)'(GRAIN - 1);
	localparam logic [DATA_W+2:0] RND3 = (DATA_W+3)'(GRAIN - 1);

	typedef struct packed {
		logic              busy;
		logic [DATA_W-1:0] len;
		logic [DATA_W-1:0] start;
	} entry_t;

	// block table
	entry_t mem [MAX_BLOCKS];

	// request capture
	op_t               op_q;
	logic [DATA_W:0]   size_q;
	logic [DATA_W-1:0] key_q;
	logic              early_q;

	// scan
	logic [CW-1:0]     idx_q;
	logic              chk_valid_s1;
	logic [IW-1:0]     chk_idx_s1;
	entry_t            rdata_s1;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	entry_t            hit_entry_q;
	logic [DATA_W+1:0] end_q;

	// heap state
	logic [CW-1:0]     total_q;
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] used_q;
	logic [LIVE_W-1:0] live_q;

	// response register
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] addr_q;
	logic [DATA_W-1:0] bytes_q;
	logic [LIVE_W-1:0] live_out_q;

	logic [DATA_W:0]   size_rnd;
	logic              more;
	logic              match;
	logic              out_free;
	logic              is_free;
	logic              oom;
	logic              full;
	logic              new_blk;
	logic              ok;
	status_t           status_c;
	logic [DATA_W-1:0] charge;
	logic [DATA_W-1:0] used_next;
	logic [LIVE_W-1:0] live_next;
	logic [DATA_W-1:0] off;
	logic [DATA_W-1:0] addr_c;
	logic [DATA_W+2:0] nxt;
	logic [DATA_W-1:0] top_next;
	logic [CW-1:0]     total_inc;
	logic              we;
	logic [IW-1:0]     waddr;
	entry_t            wdata;

	// round at 33 bits so a near-2^32 size cannot wrap to a small one
	assign size_rnd = ({1'b0, req_size} + RND) & ~RND;

	assign more  = idx_q < total_q;
	assign match = (op_q == OP_FREE) ? (rdata_s1.start == key_q)
	                                 : (!rdata_s1.busy && ({1'b0, rdata_s1.len} >= size_q));

	assign out_free = !out_valid_q || rsp_ready;

	assign sts.early     = early_q;
	assign sts.found     = chk_valid_s1 && match && !hit_q;
	assign sts.exhausted = !chk_valid_s1 && !more && !hit_q;
	assign sts.out_free  = out_free;

	// commit decision
	assign is_free = (op_q == OP_FREE);
	assign oom     = end_q > {2'b00, region_len};
	assign full    = total_q >= MAXB;

	always_comb begin
		if (is_free) begin
			if (early_q || !hit_q) begin
				status_c = ST_BADADDR;
			end else if (hit_entry_q.busy) begin
				status_c = ST_OK;
			end else begin
				status_c = ST_DOUBLE;
			end
		end else begin
			if (early_q) begin
				status_c = ST_ZERO;
			end else if (hit_q) begin
				status_c = ST_OK;
			end else if (oom) begin
				status_c = ST_OOM;
			end else if (full) begin
				status_c = ST_FULL;
			end else begin
				status_c = ST_OK;
			end
		end
	end

	assign ok      = (status_c == ST_OK);
	assign new_blk = !is_free && !early_q && !hit_q && !oom && !full;

	assign charge    = (new_blk ? size_q[DATA_W-1:0] : hit_entry_q.len) + HDR;
	assign used_next = !ok ? used_q : (is_free ? used_q - charge : used_q + charge);
	assign live_next = !ok ? live_q : (is_free ? live_q - LIVE_W'(1) : live_q + LIVE_W'(1));

	assign off    = new_blk ? top_q : hit_entry_q.start;
	assign addr_c = (ok && !is_free) ? heap_base + off + HDR : '0;

	// align the new top, saturating just below 2^32
	assign nxt      = ({1'b0, end_q} + RND3) & ~RND3;
	assign top_next = (nxt > {3'b000, TOP_LIMIT}) ? TOP_LIMIT : nxt[DATA_W-1:0];

	assign total_inc = total_q + CW'(1);

	assign we    = cmd.commit && ok;
	assign waddr = new_blk ? total_q[IW-1:0] : hit_idx_q;
	always_comb begin
		if (new_blk) begin
			wdata.busy  = 1'b1;
			wdata.len   = size_q[DATA_W-1:0];
			wdata.start = top_q;
		end else begin
			wdata.busy  = !is_free;
			wdata.len   = hit_entry_q.len;
			wdata.start = hit_entry_q.start;
		end
	end

	// single-port table: one write on commit, one registered read per scan step
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.step && more) begin
			rdata_s1 <= mem[idx_q[IW-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(op);
			size_q <= size_rnd;
			// compare stored offsets instead of rebuilding user addresses
			key_q  <= user_addr - heap_base - HDR;
		end
		if (cmd.step && more) begin
			chk_idx_s1 <= idx_q[IW-1:0];
		end
		if (cmd.step && sts.found) begin
			hit_idx_q   <= chk_idx_s1;
			hit_entry_q <= rdata_s1;
		end
		end_q <= {2'b00, top_q} + {2'b00, HDR} + {1'b0, size_q};
		if (cmd.commit) begin
			status_q   <= status_c;
			addr_q     <= addr_c;
			bytes_q    <= used_next;
			live_out_q <= live_next;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			early_q      <= 1'b0;
			idx_q        <= '0;
			chk_valid_s1 <= 1'b0;
			hit_q        <= 1'b0;
			total_q      <= '0;
			top_q        <= '0;
			used_q       <= '0;
			live_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				early_q      <= (op_t'(op) == OP_FREE) ? (user_addr == '0) : (req_size == '0);
				idx_q        <= '0;
				chk_valid_s1 <= 1'b0;
				hit_q        <= 1'b0;
			end else if (cmd.step) begin
				chk_valid_s1 <= more;
				if (more) begin
					idx_q <= idx_q + CW'(1);
				end
				if (sts.found) begin
					hit_q <= 1'b1;
				end
			end else begin
				chk_valid_s1 <= 1'b0;
			end

			if (cmd.commit) begin
				used_q <= used_next;
				live_q <= live_next;
				if (new_blk) begin
					total_q <= total_inc;
					top_q   <= top_next;
				end
			end

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = out_valid_q;
	assign status       = status_q;
	assign result_addr  = addr_q;
	assign bytes_in_use = bytes_q;
	assign live_blocks  = live_out_q;

	`FFHA_ASSERT_IMPL(a_live_le_total, clk, arst_n, 1'b1, live_q <= total_q)
	`FFHA_ASSERT_IMPL(a_commit_has_slot, clk, arst_n, cmd.commit, out_free)
	`FFHA_ASSERT_IMPL(a_top_aligned, clk, arst_n, 1'b1, top_q[2:0] == 3'b000)
	`FFHA_ASSERT_NEXT(a_new_block_counted, clk, arst_n, we && new_blk, total_q == $past(total_inc))

endmodule

// ===== hw/rtl/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator over one byte region. Each request item (allocate
// or free) yields exactly one response item carrying a status, the granted
// user address (0 unless an allocate succeeds) and the live byte and block
// totals after the request. An allocate rounds the size up to 8 and walks the
// block table in address order; the first free block that is large enough is
// reused whole, otherwise a new block with a HEADER_BYTES header is placed at
// the top of the heap and the top moves to the next multiple of 8. A free must
// name a block's user address exactly. Timing: one request is worked on at a
// time. After accept, a request scans the table entries until a match or the
// end of the table, then commits; zero-size allocates and frees of address 0
// skip the scan. The scan is paced by the block table, a single-port memory
// read once per cycle during the scan. The response sits in an output
// register, so the next request can be accepted in the cycle after the commit
// while the response waits to be taken, and only the final commit stalls on a
// full response register. No clearing pass runs after reset: only table
// entries below the block count are read, and each of those was written when
// its block was created. heap_base (offset 0) and the region length (offset 4)
// are written through the APB port; the user must write them only while the
// block is idle, and the block itself does not enforce it. Blocks are kept as
// offsets, so a new base moves all of them.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ffha_req_if.sink              req,
	ffha_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	logic [DATA_W-1:0] heap_base_q;
	logic [DATA_W-1:0] region_len_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	cmd_t cmd;
	sts_t sts;

	// configuration registers; word index sits in paddr[2]
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			region_len_q <= REGION_LEN_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_HEAP_BASE:  heap_base_q  <= pwdata;
				REG_REGION_LEN: region_len_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_HEAP_BASE:  prdata = heap_base_q;
			REG_REGION_LEN: prdata = region_len_q;
			default:        prdata = '0;
		endcase
	end

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffha_dp #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (req.op),
		.req_size     (req.req_size),
		.user_addr    (req.user_addr),
		.heap_base    (heap_base_q),
		.region_len   (region_len_q),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.status       (rsp.status),
		.result_addr  (rsp.result_addr),
		.bytes_in_use (rsp.bytes_in_use),
		.live_blocks  (rsp.live_blocks)
	);

endmodule
